[rtl/ctlr_pkg.sv]
// Shared types and constants for the cache tag lookup and replacement block.
package ctlr_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned TagW   = 32;
  localparam int unsigned StampW = 32;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_MAPPING = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_POLICY  = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET  = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_LINES   = 8'd3;

  localparam logic [1:0] MAP_DIRECT = 2'd0;
  localparam logic [1:0] MAP_FOUR   = 2'd1;
  localparam logic [1:0] MAP_FULL   = 2'd2;

  localparam logic POL_FIFO = 1'b0;
  localparam logic POL_LRU  = 1'b1;

  // One line of the tag store.
  typedef struct packed {
    logic              valid;
    logic [TagW-1:0]   tag;
    logic [StampW-1:0] stamp;
  } entry_t;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_OUT    = 5'b10000
  } state_e;

endpackage

[rtl/ctlr_tag_ram.sv]
// Single-port-write, single-port-read tag store memory with a registered read.
module ctlr_tag_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  ctlr_pkg::entry_t  wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output ctlr_pkg::entry_t  rdata_o
);
  import ctlr_pkg::*;

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/cache_tag_lookup_replace.sv]
// Top level of the cache tag lookup and replacement block.
//
// Usage: each beat on the input channel (in_valid/in_ready, address_i)
// is one access to the tag store. For each access exactly one beat leaves
// on the output channel (out_valid/out_ready): evicted_o tells whether a
// valid line was replaced and evicted_tag_o gives its old tag (zero on a
// hit or a fill). Configuration beats on the cfg channel (index 0 mapping
// mode, 1 policy, 2 offset bits, 3 lines log2) are taken at any time and
// should only be sent while the block is idle.
// Timing: the lines of the selected set are read one per cycle from the
// tag memory. Ways is 1 direct-mapped, 4 four-way, and the number of lines
// in use fully associative. An input beat is accepted only while the block
// is idle, so the next access is not taken before the previous one has been
// scanned, has updated the memory and has moved into the output register.
// Reset: after rst_ni is released a clearing pass writes every one of the
// MAX_LINES entries, one per cycle, and no input beat is accepted until the
// pass has finished. If the receiver stalls, the result is held in the output
// register while one more access is accepted and scanned; that access then
// waits after its memory update, and the input stays closed, until the
// output register has been taken.
module cache_tag_lookup_replace #(
  parameter int unsigned MAX_LINES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ctlr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ctlr_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ctlr_pkg::AddrW-1:0]    address_i,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          evicted_o,
  output logic [ctlr_pkg::TagW-1:0]     evicted_tag_o
);
  import ctlr_pkg::*;

  localparam int unsigned LineW = $clog2(MAX_LINES);
  localparam int unsigned CntW  = LineW + 1;

  // Configuration registers.
  logic [1:0] map_q;
  logic       pol_q;
  logic [3:0] off_q;
  logic [3:0] lg_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q    <= MAP_DIRECT;
      pol_q    <= POL_FIFO;
      off_q    <= 4'd4;
      lg_cfg_q <= 4'd10;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAPPING: map_q    <= cfg_data[1:0];
        CFG_POLICY:  pol_q    <= cfg_data[0];
        CFG_OFFSET:  off_q    <= cfg_data[3:0];
        CFG_LINES:   lg_cfg_q <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Address split for an incoming beat. The line count saturates to the
  // range the memory supports.
  logic [4:0]          lg;
  logic [4:0]          idx_bits;
  logic [CntW-1:0]     ways_d;
  logic [AddrW-1:0]    addr_sh;
  logic [AddrW-1:0]    set_full;
  logic [5:0]          tag_sh;
  logic [LineW-1:0]    set_line;
  logic [LineW-1:0]    base_d;

  always_comb begin
    if (lg_cfg_q < 4'd2) begin
      lg = 5'd2;
    end else if ({1'b0, lg_cfg_q} > 5'(LineW)) begin
      lg = 5'(LineW);
    end else begin
      lg = {1'b0, lg_cfg_q};
    end
    priority if (map_q == MAP_FULL) begin
      idx_bits = 5'd0;
      ways_d   = CntW'(1) << lg;
    end else if (map_q == MAP_FOUR) begin
      idx_bits = lg - 5'd2;
      ways_d   = CntW'(4);
    end else begin
      idx_bits = lg;
      ways_d   = CntW'(1);
    end
    addr_sh  = address_i >> off_q;
    set_full = addr_sh & ~({AddrW{1'b1}} << idx_bits);
    set_line = set_full[LineW-1:0];
    tag_sh   = {2'b00, off_q} + {1'b0, idx_bits};
    priority if (map_q == MAP_FULL) begin
      base_d = '0;
    end else if (map_q == MAP_FOUR) begin
      base_d = set_line << 2;
    end else begin
      base_d = set_line;
    end
  end

  // Access state.
  state_e              state_q, state_d;
  logic [CntW-1:0]     clr_q;
  logic [StampW-1:0]   count_q;
  logic [TagW-1:0]     tag_q;
  logic [LineW-1:0]    base_q;
  logic [CntW-1:0]     ways_q;
  logic [CntW-1:0]     iss_q;
  logic                rd_vld_q;
  logic                rd_first_q;
  logic [LineW-1:0]    rd_line_q;
  logic                hit_q, inv_q;
  logic [LineW-1:0]    hit_line_q, inv_line_q, vic_line_q;
  logic [StampW-1:0]   vic_stamp_q;
  logic [TagW-1:0]     vic_tag_q;
  logic                out_valid_q;
  logic                ev_q;
  logic [TagW-1:0]     ev_tag_q;

  logic                issue;
  logic                load_out;
  logic [LineW-1:0]    rd_addr;
  entry_t              rd_data;
  logic                we;
  logic [LineW-1:0]    waddr;
  entry_t              wdata;

  assign issue    = (state_q == ST_SCAN) && (iss_q < ways_q);
  assign rd_addr  = base_q + iss_q[LineW-1:0];
  // A finished access moves into the output register once it is free or
  // being emptied in the same cycle.
  assign load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready);

  always_comb begin
    state_d = state_q;
    we      = 1'b0;
    waddr   = vic_line_q;
    wdata   = '{valid: 1'b1, tag: tag_q, stamp: count_q};
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q[LineW-1:0];
        wdata = '0;
        if (clr_q == CntW'(MAX_LINES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!issue && !rd_vld_q) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        priority if (hit_q) begin
          we    = (pol_q == POL_LRU);
          waddr = hit_line_q;
        end else if (inv_q) begin
          we    = 1'b1;
          waddr = inv_line_q;
        end else begin
          we    = 1'b1;
          waddr = vic_line_q;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      inv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (state_q == ST_CLEAR) clr_q <= clr_q + CntW'(1);
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_valid && in_ready) begin
        count_q <= count_q + StampW'(1);
        iss_q   <= '0;
        hit_q   <= 1'b0;
        inv_q   <= 1'b0;
      end else begin
        if (issue) iss_q <= iss_q + CntW'(1);
        if (rd_vld_q) begin
          if (rd_data.valid && rd_data.tag == tag_q && !hit_q) hit_q <= 1'b1;
          if (!rd_data.valid && !inv_q) inv_q <= 1'b1;
        end
      end
    end
  end

  // Payload registers of the scan.
  always_ff @(posedge clk_i) begin
    if (in_valid && in_ready) begin
      tag_q  <= address_i >> tag_sh;
      base_q <= base_d;
      ways_q <= ways_d;
    end
    rd_first_q <= issue && (iss_q == '0);
    rd_line_q  <= rd_addr;
    if (rd_vld_q) begin
      if (rd_data.valid && rd_data.tag == tag_q && !hit_q) hit_line_q <= rd_line_q;
      if (!rd_data.valid && !inv_q) inv_line_q <= rd_line_q;
      // Oldest stamp wins; the lowest line keeps ties.
      if (rd_first_q || rd_data.stamp < vic_stamp_q) begin
        vic_line_q  <= rd_line_q;
        vic_stamp_q <= rd_data.stamp;
        vic_tag_q   <= rd_data.tag;
      end
    end
    if (load_out) begin
      ev_q     <= !hit_q && !inv_q;
      ev_tag_q <= (!hit_q && !inv_q) ? vic_tag_q : '0;
    end
  end

  ctlr_tag_ram #(
    .Depth (MAX_LINES),
    .AW    (LineW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign in_ready      = (state_q == ST_IDLE);
  assign out_valid     = out_valid_q;
  assign evicted_o     = ev_q;
  assign evicted_tag_o = ev_tag_q;

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (iss_q <= ways_q))
    else $error("scan ran past the set");

  a_decide_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) |=> (state_q == ST_OUT))
    else $error("decision did not move to the output step");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q || state_q == ST_CLEAR) |-> !in_ready)
    else $error("input accepted while busy");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && state_q != ST_CLEAR) |=> (state_q == ST_OUT))
    else $error("memory write outside the decision step");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(evicted_o) && $stable(evicted_tag_o)))
    else $error("output beat changed while stalled");

endmodule

[tb/sv/tb_cache_tag_lookup_replace.sv]
// Testbench for the cache tag lookup and replacement block.
module tb_cache_tag_lookup_replace;
  import ctlr_pkg::*;

  localparam int unsigned MaxLines = 1024;
  localparam int unsigned LimitCycles = 3_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [AddrW-1:0] address_i = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic evicted_o;
  logic [TagW-1:0] evicted_tag_o;

  cache_tag_lookup_replace #(.MAX_LINES(MaxLines)) dut (.*);

  always #10 clk_i = ~clk_i;

  // Shadow copy of the tag store and its registers.
  logic [1:0] mirror_map;
  logic mirror_pol;
  logic [3:0] mirror_off;
  logic [3:0] mirror_lg;
  logic mirror_valid [MaxLines];
  logic [TagW-1:0] mirror_tag [MaxLines];
  logic [StampW-1:0] mirror_stamp [MaxLines];
  logic [StampW-1:0] mirror_count;

  typedef struct packed {
    logic evicted;
    logic [TagW-1:0] tag;
  } evict_t;

  evict_t expected_evictions[$];
  logic [AddrW-1:0] pending_addresses[$];
  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_off = 0;
  bit in_fire = 1'b0;

  task automatic mirror_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    case (idx)
      CFG_MAPPING: mirror_map = val[1:0];
      CFG_POLICY: mirror_pol = val[0];
      CFG_OFFSET: mirror_off = val[3:0];
      CFG_LINES: mirror_lg = val[3:0];
      default: ;
    endcase
  endtask

  // Computes the eviction caused by one access and updates the shadow store.
  function automatic evict_t lookup_access(input logic [AddrW-1:0] addr);
    int unsigned lg, idx_bits, ways, set_no, base, l, victim;
    logic [TagW-1:0] tg;
    logic [63:0] wide;
    evict_t res;
    lg = mirror_lg < 2 ? 2 : (mirror_lg > 10 ? 10 : mirror_lg);
    mirror_count = mirror_count + 1;
    if (mirror_map == MAP_FULL) begin
      idx_bits = 0;
      ways = 1 << lg;
    end else if (mirror_map == MAP_FOUR) begin
      idx_bits = lg - 2;
      ways = 4;
    end else begin
      idx_bits = lg;
      ways = 1;
    end
    wide = {32'd0, addr} >> mirror_off;
    set_no = 32'(wide & ((64'd1 << idx_bits) - 1));
    wide = {32'd0, addr} >> (mirror_off + idx_bits);
    tg = wide[31:0];
    base = set_no * ways;
    res = '0;
    for (int unsigned i = 0; i < ways; i++) begin
      l = (base + i) % MaxLines;
      if (mirror_valid[l] && mirror_tag[l] == tg) begin
        if (mirror_pol == POL_LRU) mirror_stamp[l] = mirror_count;
        return res;
      end
    end
    for (int unsigned i = 0; i < ways; i++) begin
      l = (base + i) % MaxLines;
      if (!mirror_valid[l]) begin
        mirror_valid[l] = 1'b1;
        mirror_tag[l] = tg;
        mirror_stamp[l] = mirror_count;
        return res;
      end
    end
    victim = base % MaxLines;
    for (int unsigned i = 1; i < ways; i++) begin
      l = (base + i) % MaxLines;
      if (mirror_stamp[l] < mirror_stamp[victim]) victim = l;
    end
    res.evicted = 1'b1;
    res.tag = mirror_tag[victim];
    mirror_tag[victim] = tg;
    mirror_stamp[victim] = mirror_count;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Remembers whether an input beat was taken at the last rising edge.
  always @(posedge clk_i) begin
    in_fire <= in_valid && in_ready;
  end

  // Driver: offers queued addresses with random gaps, at the falling edge.
  int unsigned send_gap = 0;
  always @(negedge clk_i) begin
    if (in_fire) begin
      // The beat was taken at the rising edge just passed.
      void'(pending_addresses.pop_front());
      send_gap = pick_gap();
    end
    if (send_gap > 0 || pending_addresses.size() == 0) begin
      in_valid <= 1'b0;
      if (send_gap > 0) send_gap--;
    end else begin
      in_valid <= 1'b1;
      address_i <= pending_addresses[0];
    end
  end

  // Receiver readiness: random stalls, plus long hold-offs when asked.
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (pick_gap() == 0);
    end
  end

  // Monitor: predicts on input beats and checks output beats.
  always @(posedge clk_i) begin
    evict_t exp_res;
    if (rst_ni) begin
      cycle_count++;
      if (in_valid && in_ready) expected_evictions.push_back(lookup_access(address_i));
      if (out_valid && out_ready) begin
        if (expected_evictions.size() == 0) begin
          $error("result beat with no access outstanding");
          failures++;
        end else begin
          exp_res = expected_evictions.pop_front();
          if (evicted_o !== exp_res.evicted) begin
            $error("evicted: expected %0d, actual %0d", exp_res.evicted, evicted_o);
            failures++;
          end
          if (evicted_tag_o !== exp_res.tag) begin
            $error("evicted_tag: expected %08h, actual %08h", exp_res.tag, evicted_tag_o);
            failures++;
          end
        end
      end
      if (cycle_count > LimitCycles) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    mirror_write(idx, val);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued address was taken and every result checked.
  task automatic drain();
    while (pending_addresses.size() != 0 || expected_evictions.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Random address that stays within a few tags so hits and evictions mix.
  function automatic logic [AddrW-1:0] near_addr(input logic [AddrW-1:0] anchor);
    logic [AddrW-1:0] a;
    a = anchor ^ ($urandom_range(0, 7) << (5'(mirror_off) + 5'(mirror_lg)));
    a[15:0] = 16'($urandom());
    return a;
  endfunction

  task automatic run_phase(input logic [1:0] map, input logic pol,
                           input logic [3:0] off, input logic [3:0] lg,
                           input int unsigned count);
    logic [AddrW-1:0] anchor;
    write_reg(CFG_MAPPING, CfgDataW'(map));
    write_reg(CFG_POLICY, CfgDataW'(pol));
    write_reg(CFG_OFFSET, CfgDataW'(off));
    write_reg(CFG_LINES, CfgDataW'(lg));
    anchor = $urandom();
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) pending_addresses.push_back($urandom());
      else pending_addresses.push_back(near_addr(anchor));
    end
    drain();
  endtask

  initial begin
    foreach (mirror_valid[i]) begin
      mirror_valid[i] = 1'b0;
      mirror_tag[i] = '0;
      mirror_stamp[i] = '0;
    end
    mirror_map = MAP_DIRECT;
    mirror_pol = POL_FIFO;
    mirror_off = 4'd4;
    mirror_lg = 4'd10;
    mirror_count = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under reset settings: field extremes, a fill, a hit
    // and an eviction of the same direct-mapped line.
    pending_addresses.push_back(32'h0000_0000);
    pending_addresses.push_back(32'hFFFF_FFFF);
    pending_addresses.push_back(32'h0000_0000);
    pending_addresses.push_back(32'h0001_0000);
    pending_addresses.push_back(32'hAAAA_5555);
    pending_addresses.push_back(32'h5555_AAAA);
    drain();
    // Unused mapping mode acts as direct-mapped; line counts saturate.
    write_reg(CFG_MAPPING, CfgDataW'(2'd3));
    write_reg(CFG_LINES, CfgDataW'(4'd0));
    write_reg(CFG_OFFSET, CfgDataW'(4'd15));
    for (int i = 0; i < 6; i++) pending_addresses.push_back(i << 17);
    drain();
    write_reg(CFG_LINES, CfgDataW'(4'd15));
    // Shrinking the index reads old contents under a new split, which can
    // leave several lines with one tag in a set.
    write_reg(CFG_MAPPING, CfgDataW'(MAP_FOUR));
    write_reg(CFG_POLICY, CfgDataW'(POL_LRU));
    write_reg(CFG_LINES, CfgDataW'(4'd2));
    write_reg(CFG_OFFSET, CfgDataW'(4'd0));
    for (int i = 0; i < 8; i++) pending_addresses.push_back(i * 3);
    drain();

    // Long receiver stall while the sender keeps offering accesses.
    hold_off = 300;
    run_phase(MAP_FOUR, POL_FIFO, 4'd4, 4'd4, 30);

    run_phase(MAP_DIRECT, POL_FIFO, 4'd0, 4'd2, 60);
    run_phase(MAP_DIRECT, POL_LRU, 4'd12, 4'd10, 60);
    run_phase(MAP_FOUR, POL_LRU, 4'd3, 4'd3, 80);
    run_phase(MAP_FOUR, POL_FIFO, 4'd12, 4'd10, 60);
    run_phase(MAP_FULL, POL_LRU, 4'd2, 4'd2, 80);
    run_phase(MAP_FULL, POL_FIFO, 4'd0, 4'd3, 80);
    run_phase(MAP_FULL, POL_LRU, 4'd6, 4'd4, 60);
    run_phase(MAP_FULL, POL_FIFO, 4'd12, 4'd10, 12);
    run_phase(2'd3, POL_LRU, 4'd15, 4'd5, 40);

    drain();
    repeat (MaxLines + 20) @(posedge clk_i);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
